FILE: src/uol_pkg.sv
// Package for the unique ordered list block.
// Holds sizes, opcode and status codes, and the controller command struct.
// No dependencies.
package uol_pkg;

  // List geometry.
  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // Fixed field widths of the request and response beats.
  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Width used to compare a position against the fill count.
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND       = 3'd0,
    OP_INSERT_AT    = 3'd1,
    OP_REMOVE_VALUE = 3'd2,
    OP_REMOVE_AT    = 3'd3,
    OP_POP_BACK     = 3'd4,
    OP_CONTAINS     = 3'd5,
    OP_READ_AT      = 3'd6,
    OP_CLEAR        = 3'd7
  } uol_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } uol_status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the request beat
    logic exec;  // carry out the captured request and load the result
  } uol_cmd_t;

endpackage

FILE: src/uol_req_if.sv
// Request channel of the unique ordered list: valid/ready plus payload.
// Depends on uol_pkg for the field widths and the opcode type.
interface uol_req_if;
  logic                          valid;
  logic                          ready;
  uol_pkg::uol_op_e              opcode;
  logic [uol_pkg::VALUE_W-1:0]   value;
  logic [uol_pkg::POS_W-1:0]     position;

  modport source (output valid, output opcode, output value, output position, input ready);
  modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

FILE: src/uol_rsp_if.sv
// Response channel of the unique ordered list: valid/ready plus payload.
// Depends on uol_pkg for the field widths and the status type.
interface uol_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  uol_pkg::uol_status_e          status;
  logic [uol_pkg::VALUE_W-1:0]   value_out;
  logic [uol_pkg::COUNT_W-1:0]   count;

  modport source (output valid, output ok, output status, output value_out, output count,
                  input ready);
  modport sink   (input valid, input ok, input status, input value_out, input count,
                  output ready);
endinterface

FILE: src/unique_ordered_list.sv
// Top level of the unique ordered list block.
// Depends on uol_pkg, uol_req_if, uol_rsp_if, uol_ctrl and uol_dp.
//
// The block keeps an ordered list of up to CAPACITY distinct values.
// Requests arrive on req_i (opcode, value, position) as valid/ready beats;
// every request gives exactly one response beat on rsp_o (ok, status,
// value_out, count).
//
// Timing: a request beat is captured into the request registers; then, once
// the result register is free, the whole list is matched against the value
// in parallel, the entries shift by one place where needed, and the result
// register is loaded together with the response valid flag. A new request
// is taken only after the previous one has been executed. The execute cycle
// is the limit: it holds the match, the shift and the result update.
//
// Only one request is in flight. A request can be accepted while the
// previous response still waits; if the receiver stalls, the captured
// request waits in its registers until the result register is free, and
// the request channel stays closed meanwhile.
//
// Reset empties the list, clears the response valid flag and returns the
// controller to idle. The stored words are not cleared; entries beyond the count never reach a response.
module unique_ordered_list (
  input  logic       clk_i,
  input  logic       rst_ni,
  uol_req_if.sink    req_i,
  uol_rsp_if.source  rsp_o
);
  import uol_pkg::*;

  uol_cmd_t cmd;

  uol_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  uol_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .opcode_i    (req_i.opcode),
    .value_i     (req_i.value),
    .position_i  (req_i.position),
    .ok_o        (rsp_o.ok),
    .status_o    (rsp_o.status),
    .value_out_o (rsp_o.value_out),
    .count_o     (rsp_o.count)
  );

  // Only one request is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while another is in flight");

  // With the result slot empty, a response follows the request directly.
  a_prompt_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && !rsp_o.valid) |=> ##1 rsp_o.valid)
    else $error("response late although the result slot was free");

  // The list never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.count <= COUNT_W'(CAPACITY)))
    else $error("count beyond capacity");

  // The ok flag and the status code agree.
  a_ok_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.ok == (rsp_o.status == ST_OK)))
    else $error("ok flag and status disagree");

  // A failed request returns no data.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ok) |-> (rsp_o.value_out == '0))
    else $error("failed request returned data");

endmodule

FILE: src/uol_ctrl.sv
// Controller of the unique ordered list: request/execute sequencing and
// the response valid flag. Depends on uol_pkg for the command struct.
module uol_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output uol_pkg::uol_cmd_t cmd_o
);
  import uol_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } uol_state_e;

  uol_state_e state_q, state_d;
  logic       rsp_valid_q, rsp_valid_d;
  logic       slot_free;

  // The result register can take a new beat when empty or being drained.
  assign slot_free = !rsp_valid_q || rsp_ready_i;

  always_comb begin
    state_d     = state_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd_o.exec  = 1'b1;
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

FILE: src/uol_dp.sv
// Datapath of the unique ordered list: request registers, entry registers
// with parallel match and one-place shift, fill count and result registers.
// Depends on uol_pkg for sizes, codes and the command struct.
module uol_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  uol_pkg::uol_cmd_t           cmd_i,
  input  uol_pkg::uol_op_e            opcode_i,
  input  logic [uol_pkg::VALUE_W-1:0] value_i,
  input  logic [uol_pkg::POS_W-1:0]   position_i,
  output logic                        ok_o,
  output uol_pkg::uol_status_e        status_o,
  output logic [uol_pkg::VALUE_W-1:0] value_out_o,
  output logic [uol_pkg::COUNT_W-1:0] count_o
);
  import uol_pkg::*;

  uol_op_e                op_q;
  logic [DATA_WIDTH-1:0]  val_q;
  logic [POS_W-1:0]       pos_q;
  logic [DATA_WIDTH-1:0]  entry_q [CAPACITY];
  logic [DATA_WIDTH-1:0]  entry_d [CAPACITY];
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   ok_q, ok_d;
  uol_status_e            status_q, status_d;
  logic [DATA_WIDTH-1:0]  vout_q, vout_d;

  logic [CAPACITY-1:0]    match;
  logic                   hit;
  logic [IDX_W-1:0]       hit_idx;
  logic [CMP_W-1:0]       pos_ext, cnt_ext, ins_ext;
  logic [IDX_W-1:0]       ins_idx, rd_idx;
  logic [DATA_WIDTH-1:0]  rd_data;
  logic                   full, do_ins, do_rem;

  // Compare every live entry against the request value at once.
  always_comb begin
    match = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = (CNT_W'(i) < cnt_q) && (entry_q[i] == val_q);
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign hit     = |match;
  assign pos_ext = CMP_W'(pos_q);
  assign cnt_ext = CMP_W'(cnt_q);
  assign full    = (cnt_q == CNT_W'(CAPACITY));
  assign ins_ext = (op_q == OP_APPEND) ? cnt_ext : pos_ext;
  assign ins_idx = IDX_W'(ins_ext);

  // One read port serves read-at and all three kinds of removal.
  always_comb begin
    case (op_q)
      OP_REMOVE_VALUE: rd_idx = hit_idx;
      OP_POP_BACK:     rd_idx = IDX_W'(cnt_q - 1'b1);
      default:         rd_idx = IDX_W'(pos_q);
    endcase
  end

  assign rd_data = entry_q[rd_idx];

  always_comb begin
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    ok_d     = 1'b0;
    status_d = ST_MISS;
    vout_d   = '0;
    cnt_d    = cnt_q;
    unique case (op_q)
      OP_APPEND, OP_INSERT_AT: begin
        if (hit) begin
          status_d = ST_DUP;
        end else if (full) begin
          status_d = ST_FULL;
        end else if (ins_ext <= cnt_ext) begin
          do_ins   = 1'b1;
          ok_d     = 1'b1;
          status_d = ST_OK;
          cnt_d    = cnt_q + 1'b1;
        end
      end
      OP_REMOVE_VALUE: begin
        if (hit) begin
          do_rem   = 1'b1;
          ok_d     = 1'b1;
          status_d = ST_OK;
          vout_d   = rd_data;
          cnt_d    = cnt_q - 1'b1;
        end
      end
      OP_REMOVE_AT: begin
        if (pos_ext < cnt_ext) begin
          do_rem   = 1'b1;
          ok_d     = 1'b1;
          status_d = ST_OK;
          vout_d   = rd_data;
          cnt_d    = cnt_q - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (cnt_q != '0) begin
          do_rem   = 1'b1;
          ok_d     = 1'b1;
          status_d = ST_OK;
          vout_d   = rd_data;
          cnt_d    = cnt_q - 1'b1;
        end
      end
      OP_CONTAINS: begin
        if (hit) begin
          ok_d     = 1'b1;
          status_d = ST_OK;
        end
      end
      OP_READ_AT: begin
        if (pos_ext < cnt_ext) begin
          ok_d     = 1'b1;
          status_d = ST_OK;
          vout_d   = rd_data;
        end
      end
      OP_CLEAR: begin
        ok_d     = 1'b1;
        status_d = ST_OK;
        cnt_d    = '0;
      end
      default: begin
        status_d = ST_MISS;
      end
    endcase
  end

  // Insert moves entries at and above the slot up one place; removal moves
  // entries above the slot down one place. Each entry looks only at its
  // two neighbors.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      entry_d[i] = entry_q[i];
      if (do_ins) begin
        if (IDX_W'(i) > ins_idx) begin
          entry_d[i] = entry_q[(i == 0) ? 0 : i - 1];
        end else if (IDX_W'(i) == ins_idx) begin
          entry_d[i] = val_q;
        end
      end else if (do_rem && (IDX_W'(i) >= rd_idx)) begin
        entry_d[i] = entry_q[(i == CAPACITY - 1) ? i : i + 1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      val_q <= DATA_WIDTH'(value_i);
      pos_q <= position_i;
    end
    if (cmd_i.exec) begin
      entry_q  <= entry_d;
      ok_q     <= ok_d;
      status_q <= status_d;
      vout_q   <= vout_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.exec) begin
      cnt_q <= cnt_d;
    end
  end

  // The count changes only on execute, which waits for a free result slot,
  // so it stays stable while a result beat is pending.
  assign ok_o        = ok_q;
  assign status_o    = status_q;
  assign value_out_o = VALUE_W'(vout_q);
  assign count_o     = COUNT_W'(cnt_q);

endmodule

FILE: dv/tb_top.sv
// Testbench for the unique ordered list block: directed, backpressure and random tests.
// Depends on uol_pkg, uol_req_if, uol_rsp_if and unique_ordered_list.
// A local list image predicts every response beat, and a checker compares it field by field.
`timescale 1ns / 1ps

module tb_top;
  import uol_pkg::*;

  // One predicted response beat, in the field layout of the response channel.
  typedef struct {
    logic                  ok;
    uol_status_e           status;
    logic [VALUE_W-1:0]    value_out;
    logic [COUNT_W-1:0]    count;
  } list_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  uol_req_if req_if ();
  uol_rsp_if rsp_if ();

  unique_ordered_list dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Local image of the list. Only the first list_len words mean anything,
  // just as in the block, so stale words after a clear are never compared.
  logic [DATA_WIDTH-1:0] list_img [CAPACITY];
  int                    list_len = 0;

  // Responses still owed by the block, oldest first.
  list_rsp_t pending_rsp_q [$];

  // Idle and stall rates in percent, changed between test phases.
  int unsigned req_idle_pct  = 0;
  int unsigned rsp_stall_pct = 0;

  // A long receiver hold-off is requested through hold_len and counted down
  // by the ready process itself.
  int unsigned hold_len  = 0;
  int unsigned hold_left = 0;

  int unsigned mismatch_cnt = 0;
  int unsigned rsp_cnt      = 0;
  int unsigned op_cnt     [8];
  int unsigned status_cnt [4];

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Index of a value within the live part of the list, or -1.
  function automatic int find_entry(logic [DATA_WIDTH-1:0] val);
    for (int i = 0; i < list_len; i++) begin
      if (list_img[i] == val) return i;
    end
    return -1;
  endfunction

  // Removes one entry and closes the gap by moving later entries down.
  function automatic logic [DATA_WIDTH-1:0] take_entry(int at);
    logic [DATA_WIDTH-1:0] val;
    val = list_img[at];
    for (int i = at; i + 1 < list_len; i++) begin
      list_img[i] = list_img[i + 1];
    end
    list_len--;
    return val;
  endfunction

  // Applies one request to the list image and returns the response it owes.
  // On inserts the duplicate check wins over the full check, which wins over
  // the position range check. A position equal to the count appends.
  function automatic list_rsp_t predict_list_op(uol_op_e op, logic [VALUE_W-1:0] val,
                                                logic [POS_W-1:0] pos);
    list_rsp_t r;
    int        at;
    int        slot;
    r.status    = ST_MISS;
    r.value_out = '0;
    at   = find_entry(val[DATA_WIDTH-1:0]);
    slot = (op == OP_APPEND) ? list_len : int'(pos);
    case (op)
      OP_APPEND, OP_INSERT_AT: begin
        if (at >= 0) begin
          r.status = ST_DUP;
        end else if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (slot <= list_len) begin
          for (int i = list_len; i > slot; i--) begin
            list_img[i] = list_img[i - 1];
          end
          list_img[slot] = val[DATA_WIDTH-1:0];
          list_len++;
          r.status = ST_OK;
        end
      end
      OP_REMOVE_VALUE: begin
        if (at >= 0) begin
          r.value_out = take_entry(at);
          r.status    = ST_OK;
        end
      end
      OP_REMOVE_AT: begin
        if (int'(pos) < list_len) begin
          r.value_out = take_entry(int'(pos));
          r.status    = ST_OK;
        end
      end
      OP_POP_BACK: begin
        if (list_len > 0) begin
          r.value_out = take_entry(list_len - 1);
          r.status    = ST_OK;
        end
      end
      OP_CONTAINS: begin
        if (at >= 0) r.status = ST_OK;
      end
      OP_READ_AT: begin
        if (int'(pos) < list_len) begin
          r.value_out = list_img[int'(pos)];
          r.status    = ST_OK;
        end
      end
      default: begin
        // Clear only drops the count; the stored words stay as they were.
        list_len = 0;
        r.status = ST_OK;
      end
    endcase
    // Every success reports status ok, and every failure a nonzero status.
    r.ok    = (r.status == ST_OK);
    r.count = COUNT_W'(list_len);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offers one request beat. Valid stays high after a beat is taken, so the
  // next call either drops it for an idle cycle or replaces the payload at
  // the following falling edge; each edge sees one assignment at most.
  task automatic send_req(uol_op_e op, logic [VALUE_W-1:0] val, logic [POS_W-1:0] pos);
    @(negedge clk_i);
    while ($urandom_range(99) < req_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.opcode   <= op;
    req_if.value    <= val;
    req_if.position <= pos;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    // The beat is taken at this edge: predict now, in acceptance order.
    pending_rsp_q.push_back(predict_list_op(op, val, pos));
    op_cnt[op]++;
  endtask

  // The sender drops valid, so the last beat is not taken again, and pauses
  // until the block owes nothing.
  task automatic wait_list_idle();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Response side
  // ---------------------------------------------------------------------------

  // Ready is driven at the falling edge. A requested hold-off keeps it low
  // for a counted stretch; otherwise it stalls at the phase's random rate.
  always @(negedge clk_i) begin
    if (hold_len != 0) begin
      hold_left = hold_len;
      hold_len  = 0;
    end
    if (hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      hold_left--;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  task automatic report_mismatch(string msg);
    if (mismatch_cnt < 40) $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("response %0d %s got 0x%0h expected 0x%0h",
                                rsp_cnt, name, got, want));
    end
  endtask

  // Every response beat is compared with the oldest prediction.
  always @(posedge clk_i) begin
    list_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch($sformatf("response %0d arrived with none owed", rsp_cnt));
      end else begin
        want = pending_rsp_q.pop_front();
        check_field("ok",        32'(rsp_if.ok),     32'(want.ok));
        check_field("status",    32'(rsp_if.status), 32'(want.status));
        check_field("value_out", rsp_if.value_out,   want.value_out);
        check_field("count",     32'(rsp_if.count),  32'(want.count));
        status_cnt[want.status]++;
      end
      rsp_cnt++;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Short directed run over the empty list, the duplicate and position rules
  // for inserts, the read and removal limits, and clear with stale words left behind.
  task automatic test_directed_edges();
    req_idle_pct  = 0;
    rsp_stall_pct = 0;
    // Every operation that needs an entry must fail on the empty list.
    send_req(OP_POP_BACK,     32'h0,         5'd0);
    send_req(OP_READ_AT,      32'h0,         5'd0);
    send_req(OP_REMOVE_AT,    32'h0,         5'd0);
    send_req(OP_REMOVE_VALUE, 32'h5,         5'd0);
    send_req(OP_CONTAINS,     32'h0,         5'd0);
    // Extreme values, a push to the front, an insert at the count, and an
    // insert one place past the count.
    send_req(OP_APPEND,       32'h0,         5'd0);
    send_req(OP_APPEND,       32'hFFFF_FFFF, 5'd0);
    send_req(OP_INSERT_AT,    32'hA5A5_5A5A, 5'd0);
    send_req(OP_INSERT_AT,    32'h0000_0001, 5'd3);
    send_req(OP_INSERT_AT,    32'h0000_0007, 5'd5);
    // Duplicates are refused, even with a wild position.
    send_req(OP_APPEND,       32'hFFFF_FFFF, 5'd0);
    send_req(OP_INSERT_AT,    32'h0,         5'd31);
    // Reads at the last entry, at the count and at the largest position.
    send_req(OP_READ_AT,      32'h0,         5'd3);
    send_req(OP_READ_AT,      32'h0,         5'd4);
    send_req(OP_READ_AT,      32'h0,         5'd31);
    send_req(OP_CONTAINS,     32'hFFFF_FFFF, 5'd0);
    // Removals from the middle by value and by position and from the back, then one out of range.
    send_req(OP_REMOVE_VALUE, 32'h0,         5'd0);
    send_req(OP_REMOVE_AT,    32'h0,         5'd1);
    send_req(OP_POP_BACK,     32'h0,         5'd0);
    send_req(OP_REMOVE_AT,    32'h0,         5'd16);
    // After a clear the old words must be invisible.
    send_req(OP_CLEAR,        32'h0,         5'd0);
    send_req(OP_READ_AT,      32'h0,         5'd0);
    send_req(OP_APPEND,       32'h5A5A_A5A5, 5'd0);
    send_req(OP_CONTAINS,     32'hA5A5_5A5A, 5'd0);
    wait_list_idle();
  endtask

  // Holds the receiver off for a long stretch while the sender keeps offering
  // appends, so the block backs up and closes its request channel. The list
  // fills to capacity, and then the duplicate and full rules are checked
  // against a full list.
  task automatic test_backpressure_fill();
    req_idle_pct  = 0;
    rsp_stall_pct = 0;
    send_req(OP_CLEAR, 32'h0, 5'd0);
    @(posedge clk_i);
    hold_len = 60;
    for (int i = 0; i < CAPACITY + 2; i++) begin
      send_req(OP_APPEND, 32'h8000_0000 + i * 32'h0101_0101, 5'(i));
    end
    // While full, a held value still reports a duplicate, and a position
    // past the count reports full rather than out of range.
    send_req(OP_INSERT_AT, 32'h8000_0000, 5'd0);
    send_req(OP_INSERT_AT, 32'h0000_1234, 5'd20);
    wait_list_idle();
  endtask

  // Random mix, weighted toward inserts so the list drifts up to full, with
  // values drawn often from the list or a small pool so duplicates and hits
  // are common. Runs once per phase of idle and stall rates.
  task automatic test_random_mix(int unsigned n_items);
    int unsigned        idle_set  [4] = '{0, 62, 0, 19};
    int unsigned        stall_set [4] = '{0, 0, 62, 19};
    int unsigned        pick;
    uol_op_e            op;
    logic [VALUE_W-1:0] val;
    logic [POS_W-1:0]   pos;
    for (int ph = 0; ph < 4; ph++) begin
      req_idle_pct  = idle_set[ph];
      rsp_stall_pct = stall_set[ph];
      for (int unsigned n = 0; n < n_items; n++) begin
        pick = $urandom_range(99);
        if (pick < 18)      op = OP_APPEND;
        else if (pick < 36) op = OP_INSERT_AT;
        else if (pick < 48) op = OP_REMOVE_VALUE;
        else if (pick < 58) op = OP_REMOVE_AT;
        else if (pick < 66) op = OP_POP_BACK;
        else if (pick < 78) op = OP_CONTAINS;
        else if (pick < 98) op = OP_READ_AT;
        else                op = OP_CLEAR;
        pick = $urandom_range(9);
        if (pick < 4 && list_len > 0) val = list_img[$urandom_range(list_len - 1)];
        else if (pick < 7)            val = $urandom_range(15);
        else                          val = $urandom();
        // Positions mostly near the live range, sometimes anywhere.
        if ($urandom_range(3) == 0) pos = POS_W'($urandom_range(31));
        else                        pos = POS_W'($urandom_range(list_len + 1));
        send_req(op, val, pos);
      end
      // The sender pauses at each phase boundary until all responses are in.
      wait_list_idle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence and end of run
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.opcode   = OP_APPEND;
    req_if.value    = '0;
    req_if.position = '0;
    rsp_if.ready    = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_edges();
    test_backpressure_fill();
    test_random_mix(430);

    @(negedge clk_i);
    req_if.valid <= 1'b0;
    wait_list_idle();
    // Keep running to catch any stray response beat.
    repeat (10) @(posedge clk_i);

    $display("Checked %0d responses: %0d ok, %0d duplicate, %0d full, %0d miss.",
             rsp_cnt, status_cnt[ST_OK], status_cnt[ST_DUP], status_cnt[ST_FULL],
             status_cnt[ST_MISS]);
    $display("Requests per opcode 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             op_cnt[0], op_cnt[1], op_cnt[2], op_cnt[3],
             op_cnt[4], op_cnt[5], op_cnt[6], op_cnt[7]);
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #1_000_000;
    $display("Timeout with %0d responses still owed", pending_rsp_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: filelist.f
src/uol_pkg.sv
src/uol_req_if.sv
src/uol_rsp_if.sv
src/uol_ctrl.sv
src/uol_dp.sv
src/unique_ordered_list.sv
dv/tb_top.sv
